// ===== rtl/hex_grid_neighbor_list_generator_core_macros.svh =====
// assertion macros shared by the neighbour list generator
`ifndef HEX_GRID_NEIGHBOR_LIST_GENERATOR_CORE_MACROS_SVH
`define HEX_GRID_NEIGHBOR_LIST_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTH
`define HGNL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HGNL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HGNL_ASSERT_IMP(name, ante, cons, msg)
`define HGNL_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

// ===== rtl/hgnl_pkg.sv =====
// shared types and constants of the grid neighbour list generator
`timescale 1ns / 1ps
package hgnl_pkg;

  localparam int unsigned IDX_W      = 8;
  localparam int unsigned ID_W       = 24;
  localparam int unsigned ROW_W      = 29;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned POS_W      = 40;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z  = 3'd5;

  typedef struct packed {
    logic [IDX_W-1:0]  nx;
    logic [IDX_W-1:0]  ny;
    logic [IDX_W-1:0]  nz;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [STEP_W-1:0] step_z;
  } grid_cfg_t;

  // one node handed from the front to the back
  typedef struct packed {
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic [ROW_W-1:0] row_start;
    logic [CNT_W-1:0] count;
    logic             final_node;
  } node_job_t;

  // number of in-bounds positions along one axis: 1, 2 or 3
  function automatic logic [1:0] axis_span(input logic [IDX_W-1:0] idx,
                                           input logic [IDX_W-1:0] n);
    logic [1:0] s;
    s = 2'd1;
    if (idx != '0) s = s + 2'd1;
    if (idx < n)   s = s + 2'd1;
    return s;
  endfunction

endpackage

// ===== rtl/hgnl_queue.sv =====
// small register queue carrying node jobs from front to back
`timescale 1ns / 1ps
module hgnl_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hgnl_pkg::node_job_t din,
  output logic                not_full,
  input  logic                take,
  output logic                not_empty,
  output hgnl_pkg::node_job_t dout
);
  import hgnl_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  node_job_t         slots [DEPTH];
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign not_full  = (fill != FILL_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && not_full;
  assign do_pop    = take && not_empty;
  assign dout      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/hgnl_front.sv =====
// walk front: takes advance beats, keeps the node walk and row offset
`timescale 1ns / 1ps
module hgnl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                restart,
  input  hgnl_pkg::grid_cfg_t cfg,
  output logic                push,
  output hgnl_pkg::node_job_t job,
  input  logic                q_not_full
);
  import hgnl_pkg::*;

  logic [IDX_W-1:0] walk_i;
  logic [IDX_W-1:0] walk_j;
  logic [IDX_W-1:0] walk_k;
  logic [ROW_W-1:0] entry_cursor;

  logic             wrap;
  logic [IDX_W-1:0] ci;
  logic [IDX_W-1:0] cj;
  logic [IDX_W-1:0] ck;
  logic [ROW_W-1:0] cursor;
  logic [3:0]       span_xy;
  logic [5:0]       span_xyz;
  logic [CNT_W-1:0] count;
  logic             final_node;

  assign in_ready = q_not_full;
  assign push     = in_valid && q_not_full;

  always_comb begin
    // a walk left outside the grid by a new size restarts as well
    wrap     = restart || (walk_i > cfg.nx) || (walk_j > cfg.ny) || (walk_k > cfg.nz);
    ci       = wrap ? '0 : walk_i;
    cj       = wrap ? '0 : walk_j;
    ck       = wrap ? '0 : walk_k;
    cursor   = wrap ? '0 : entry_cursor;
    span_xy  = {2'b00, axis_span(ci, cfg.nx)} * {2'b00, axis_span(cj, cfg.ny)};
    span_xyz = {2'b00, span_xy} * {4'b0000, axis_span(ck, cfg.nz)};
    count    = CNT_W'(span_xyz - 6'd1);
    final_node = (ci == cfg.nx) && (cj == cfg.ny) && (ck == cfg.nz);

    job.i          = ci;
    job.j          = cj;
    job.k          = ck;
    job.row_start  = cursor;
    job.count      = count;
    job.final_node = final_node;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_i       <= '0;
      walk_j       <= '0;
      walk_k       <= '0;
      entry_cursor <= '0;
    end else if (push) begin
      if (final_node) begin
        walk_i       <= '0;
        walk_j       <= '0;
        walk_k       <= '0;
        entry_cursor <= '0;
      end else begin
        entry_cursor <= cursor + {{(ROW_W-CNT_W){1'b0}}, count};
        if (ci < cfg.nx) begin
          walk_i <= ci + IDX_W'(1);
          walk_j <= cj;
          walk_k <= ck;
        end else if (cj < cfg.ny) begin
          walk_i <= '0;
          walk_j <= cj + IDX_W'(1);
          walk_k <= ck;
        end else begin
          walk_i <= '0;
          walk_j <= '0;
          walk_k <= ck + IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/hgnl_back.sv =====
// emit back: per node index setup, then a sweep of the 27 stencil offsets
`timescale 1ns / 1ps
module hgnl_back (
  input  logic                        clk,
  input  logic                        rst,
  input  hgnl_pkg::grid_cfg_t         cfg,
  input  logic                        q_not_empty,
  output logic                        q_take,
  input  hgnl_pkg::node_job_t         job,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hgnl_pkg::ID_W-1:0]   node_id,
  output logic [hgnl_pkg::ID_W-1:0]   neighbor_id,
  output logic [hgnl_pkg::ROW_W-1:0]  row_start,
  output logic                        is_constrained,
  output logic [hgnl_pkg::POS_W-1:0]  pos_x,
  output logic [hgnl_pkg::POS_W-1:0]  pos_y,
  output logic [hgnl_pkg::POS_W-1:0]  pos_z,
  output logic                        last_of_node,
  output logic                        last_of_mesh
);
  import hgnl_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_NODE  = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  localparam logic [1:0] OFF_NEG = 2'd0;
  localparam logic [1:0] OFF_MID = 2'd1;
  localparam logic [1:0] OFF_POS = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  node_job_t        cur;
  logic [15:0]      col_base;
  logic [16:0]      plane;
  logic [ID_W-1:0]  node_reg;
  logic [POS_W-1:0] px;
  logic [POS_W-1:0] py;
  logic [POS_W-1:0] pz;
  logic [1:0]       ox;
  logic [1:0]       oy;
  logic [1:0]       oz;
  logic [CNT_W-1:0] emitted;

  logic [8:0]       row_len;
  logic [8:0]       col_len;
  logic [17:0]      col_prod;
  logic [17:0]      plane_prod;
  logic [24:0]      node_prod;
  logic             off_valid;
  logic             out_free;
  logic             emit;
  logic             adv;
  logic             at_end;
  logic             is_last;
  logic [ID_W-1:0]  dx_term;
  logic [ID_W-1:0]  dy_term;
  logic [ID_W-1:0]  dz_term;
  logic [ID_W-1:0]  nbr;

  function automatic logic axis_ok(input logic [1:0] code, input logic [IDX_W-1:0] idx,
                                   input logic [IDX_W-1:0] n);
    logic ok;
    unique case (code)
      OFF_NEG: ok = (idx != '0);
      OFF_MID: ok = 1'b1;
      OFF_POS: ok = (idx != n);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign q_take = (state == ST_IDLE);

  always_comb begin
    row_len    = {1'b0, cfg.nx} + 9'd1;
    col_len    = {1'b0, cfg.ny} + 9'd1;
    col_prod   = col_len * {1'b0, cur.k};
    plane_prod = row_len * col_len;
    node_prod  = row_len * col_base;

    off_valid = axis_ok(ox, cur.i, cfg.nx) && axis_ok(oy, cur.j, cfg.ny) &&
                axis_ok(oz, cur.k, cfg.nz) &&
                !((ox == OFF_MID) && (oy == OFF_MID) && (oz == OFF_MID));
    out_free  = !out_valid || out_ready;
    emit      = (state == ST_SWEEP) && off_valid && out_free;
    adv       = (state == ST_SWEEP) && (!off_valid || out_free);
    at_end    = (ox == OFF_POS) && (oy == OFF_POS) && (oz == OFF_POS);
    is_last   = (emitted == CNT_W'(cur.count - CNT_W'(1)));

    unique case (ox)
      OFF_NEG: dx_term = '1;
      OFF_POS: dx_term = ID_W'(1);
      default: dx_term = '0;
    endcase
    unique case (oy)
      OFF_NEG: dy_term = '0 - {{(ID_W-9){1'b0}}, row_len};
      OFF_POS: dy_term = {{(ID_W-9){1'b0}}, row_len};
      default: dy_term = '0;
    endcase
    unique case (oz)
      OFF_NEG: dz_term = '0 - {{(ID_W-17){1'b0}}, plane};
      OFF_POS: dz_term = {{(ID_W-17){1'b0}}, plane};
      default: dz_term = '0;
    endcase
    // neighbour index as an offset from the node, wrapping like the index
    nbr = node_reg + dx_term + dy_term + dz_term;

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_not_empty) begin
          state_next = (job.count != '0) ? ST_SETUP : ST_IDLE;
        end
      end
      ST_SETUP: state_next = ST_NODE;
      ST_NODE:  state_next = ST_SWEEP;
      ST_SWEEP: begin
        if ((emit && is_last) || (adv && at_end)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ox      <= OFF_NEG;
      oy      <= OFF_NEG;
      oz      <= OFF_NEG;
      emitted <= '0;
    end else begin
      state <= state_next;
      if (state == ST_NODE) begin
        ox      <= OFF_NEG;
        oy      <= OFF_NEG;
        oz      <= OFF_NEG;
        emitted <= '0;
      end else if (adv) begin
        if (emit) begin
          emitted <= emitted + CNT_W'(1);
        end
        if (ox == OFF_POS) begin
          ox <= OFF_NEG;
          if (oy == OFF_POS) begin
            oy <= OFF_NEG;
            oz <= oz + 2'd1;
          end else begin
            oy <= oy + 2'd1;
          end
        end else begin
          ox <= ox + 2'd1;
        end
      end
    end
  end

  // per node setup, one multiply deep per cycle
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && q_not_empty) begin
      cur <= job;
    end
    if (state == ST_SETUP) begin
      col_base <= col_prod[15:0] + {8'b0, cur.j};
      plane    <= plane_prod[16:0];
      px       <= {{(POS_W-IDX_W){1'b0}}, cur.i} * {{(POS_W-STEP_W){1'b0}}, cfg.step_x};
      py       <= {{(POS_W-IDX_W){1'b0}}, cur.j} * {{(POS_W-STEP_W){1'b0}}, cfg.step_y};
      pz       <= {{(POS_W-IDX_W){1'b0}}, cur.k} * {{(POS_W-STEP_W){1'b0}}, cfg.step_z};
    end
    if (state == ST_NODE) begin
      node_reg <= node_prod[ID_W-1:0] + {{(ID_W-IDX_W){1'b0}}, cur.i};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      node_id        <= node_reg;
      neighbor_id    <= nbr;
      row_start      <= cur.row_start;
      is_constrained <= (cur.i == '0);
      pos_x          <= px;
      pos_y          <= py;
      pos_z          <= pz;
      last_of_node   <= is_last;
      last_of_mesh   <= is_last && cur.final_node;
    end
  end

endmodule

// ===== rtl/hex_grid_neighbor_list_generator_core.sv =====
// top level of the structured grid 26-neighbour adjacency generator
//
//   channel | direction | handshake            | beat carries
//   --------+-----------+----------------------+---------------------------------------
//   in      | into core | in_valid / in_ready  | restart
//   out     | from core | out_valid / out_ready| node, neighbour, offset, coords, flags
//   cfg     | into core | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// the front takes one advance beat per cycle, while the queue has room, into a short job
// queue; the back runs index setup per node (ST_SETUP, ST_NODE), then one stencil offset
// per clock while the output is not stalled; a node with no neighbours (a grid of a single node) is skipped.
// synchronous reset: walk at node zero, offset zero, registers at their defaults.
// a stalled output holds the sweep; a full queue drops in_ready. cfg_ready is always high.
`timescale 1ns / 1ps
module hex_grid_neighbor_list_generator_core #(
  parameter int unsigned MAX_CELLS   = 255,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hgnl_pkg::ID_W-1:0]         node_id,
  output logic [hgnl_pkg::ID_W-1:0]         neighbor_id,
  output logic [hgnl_pkg::ROW_W-1:0]        row_start,
  output logic                              is_constrained,
  output logic [hgnl_pkg::POS_W-1:0]        pos_x,
  output logic [hgnl_pkg::POS_W-1:0]        pos_y,
  output logic [hgnl_pkg::POS_W-1:0]        pos_z,
  output logic                              last_of_node,
  output logic                              last_of_mesh,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hgnl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hgnl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hgnl_pkg::*;
  `include "hex_grid_neighbor_list_generator_core_macros.svh"

  localparam int unsigned CELL_LIM = (MAX_CELLS > 255) ? 255 : MAX_CELLS;

  logic [IDX_W-1:0]  cells_x;
  logic [IDX_W-1:0]  cells_y;
  logic [IDX_W-1:0]  cells_z;
  logic [STEP_W-1:0] step_x;
  logic [STEP_W-1:0] step_y;
  logic [STEP_W-1:0] step_z;
  grid_cfg_t         grid;
  logic              q_push;
  logic              q_not_full;
  logic              q_not_empty;
  logic              q_take;
  node_job_t         job_in;
  node_job_t         job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= IDX_W'(1);
      cells_y <= IDX_W'(1);
      cells_z <= IDX_W'(1);
      step_x  <= STEP_W'(65536);
      step_y  <= STEP_W'(65536);
      step_z  <= STEP_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CELLS_X: cells_x <= cfg_data[IDX_W-1:0];
        REG_CELLS_Y: cells_y <= cfg_data[IDX_W-1:0];
        REG_CELLS_Z: cells_z <= cfg_data[IDX_W-1:0];
        REG_STEP_X:  step_x  <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:  step_y  <= cfg_data[STEP_W-1:0];
        REG_STEP_Z:  step_z  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // cell counts saturate at the grid limit
  always_comb begin
    grid.nx     = (cells_x > IDX_W'(CELL_LIM)) ? IDX_W'(CELL_LIM) : cells_x;
    grid.ny     = (cells_y > IDX_W'(CELL_LIM)) ? IDX_W'(CELL_LIM) : cells_y;
    grid.nz     = (cells_z > IDX_W'(CELL_LIM)) ? IDX_W'(CELL_LIM) : cells_z;
    grid.step_x = step_x;
    grid.step_y = step_y;
    grid.step_z = step_z;
  end

  hgnl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .cfg        (grid),
    .push       (q_push),
    .job        (job_in),
    .q_not_full (q_not_full)
  );

  hgnl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (job_in),
    .not_full  (q_not_full),
    .take      (q_take),
    .not_empty (q_not_empty),
    .dout      (job_out)
  );

  hgnl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (grid),
    .q_not_empty    (q_not_empty),
    .q_take         (q_take),
    .job            (job_out),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .node_id        (node_id),
    .neighbor_id    (neighbor_id),
    .row_start      (row_start),
    .is_constrained (is_constrained),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .last_of_node   (last_of_node),
    .last_of_mesh   (last_of_mesh)
  );

  `HGNL_ASSERT_IMP(a_mesh_end_ends_node, out_valid && last_of_mesh, last_of_node, "mesh end early")
  `HGNL_ASSERT_IMP(a_no_self_edge, out_valid, node_id != neighbor_id, "self neighbour")
  `HGNL_ASSERT_IMP(a_constrained_at_origin, out_valid && is_constrained, pos_x == '0, "x set")
  `HGNL_ASSERT_NXT(a_queue_holds_push, q_push && !(q_take && q_not_empty), q_not_empty, "lost")

endmodule
